// File: rtl/u8u16_pkg.sv
package u8u16_pkg;

   // UTF-16 code unit width and surrogate arithmetic
   localparam int unsigned WORD_W     = 16;
   localparam int unsigned CODE_W     = 21;
   localparam logic [CODE_W-1:0] SUPP_BASE  = 21'h10000;
   localparam logic [WORD_W-1:0] HIGH_SURR  = 16'hD800;
   localparam logic [WORD_W-1:0] LOW_SURR   = 16'hDC00;

   // Lead bytes whose first continuation needs a range check
   localparam logic [4:0] LEAD3_OVERLONG = 5'h00;
   localparam logic [4:0] LEAD3_SURR     = 5'h0D;
   localparam logic [4:0] LEAD4_OVERLONG = 5'h00;
   localparam logic [4:0] LEAD4_TOP      = 5'h04;

   // Continuation counts of a sequence
   localparam logic [1:0] SEQ_TWO   = 2'd1;
   localparam logic [1:0] SEQ_THREE = 2'd2;
   localparam logic [1:0] SEQ_FOUR  = 2'd3;

   // One result beat
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              err;
      logic              last;
   } rsp_entry_type;

endpackage

// File: rtl/utf8_to_utf16_decoder_top.sv
// An accepted byte is registered in the input stage and decoded there; its words go to rsp via the result buffer.
// One byte per cycle while the result buffer has room; a surrogate pair takes two beats of
// the single result port, so a four-byte character yields two output beats.
// A two-entry result buffer parts the decode stage from the result channel.
// Reset (synchronous, active high) empties the input stage and result buffer and
// returns the decoder to idle with no partial character.
module utf8_to_utf16_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] word_out
   output logic        rsp_tuser,   // [0] is_error
   output logic        rsp_tlast    // last_of_run
);

   // Input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;

   // Decoder state
   logic [u8u16_pkg::CODE_W-1:0] acc_ff, acc_in;
   logic [1:0] rem_ff, rem_in;
   logic [1:0] seq_ff, seq_in;
   logic       first_ff, first_in;

   // Result buffer
   u8u16_pkg::rsp_entry_type e0_ff, e0_in, e1_ff, e1_in, base0;
   logic [1:0] cnt_ff, cnt_in, cnt_p;

   // Decode outputs
   u8u16_pkg::rsp_entry_type r0, r1;
   logic [1:0] res_n;
   logic       fail;
   logic       advance, pop;

   logic [u8u16_pkg::CODE_W-1:0] acc_sh, cp_off;
   logic [1:0] rem_dec;
   logic       lead2, lead3, lead4, bad_lead, cont_ok, first_bad;

   // Classify the byte in the input stage
   always_comb begin
      lead2   = (in_byte_ff[7:5] == 3'b110);
      lead3   = (in_byte_ff[7:4] == 4'b1110);
      lead4   = (in_byte_ff[7:3] == 5'b11110);
      bad_lead = !(lead2 || lead3 || lead4)
               || (lead2 && (in_byte_ff[4:1] == 4'd0))
               || (lead4 && (in_byte_ff[2:0] > 3'd4));
      cont_ok = (in_byte_ff[7:6] == 2'b10);
      first_bad = 1'b0;
      if (first_ff) begin
         if (seq_ff == u8u16_pkg::SEQ_THREE) begin
            first_bad = ((acc_ff[4:0] == u8u16_pkg::LEAD3_OVERLONG) && !in_byte_ff[5])
                     || ((acc_ff[4:0] == u8u16_pkg::LEAD3_SURR) && in_byte_ff[5]);
         end else if (seq_ff == u8u16_pkg::SEQ_FOUR) begin
            first_bad = ((acc_ff[4:0] == u8u16_pkg::LEAD4_OVERLONG)
                         && (in_byte_ff[5:4] == 2'b00))
                     || ((acc_ff[4:0] == u8u16_pkg::LEAD4_TOP)
                         && (in_byte_ff[5:4] != 2'b00));
         end
      end
      acc_sh  = {acc_ff[u8u16_pkg::CODE_W-7:0], in_byte_ff[5:0]};
      rem_dec = rem_ff - 2'd1;
      cp_off  = acc_sh - u8u16_pkg::SUPP_BASE;
   end

   // Decode: next state and up to two result beats
   always_comb begin
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      seq_in   = seq_ff;
      first_in = first_ff;
      res_n    = 2'd0;
      fail     = 1'b0;
      r0       = '0;
      r1       = '0;
      if (rem_ff == 2'd0) begin
         if (!in_byte_ff[7]) begin
            res_n   = 2'd1;
            r0.word = {8'h00, in_byte_ff};
            r0.last = 1'b1;
         end else if (bad_lead || in_eos_ff) begin
            fail = 1'b1;
         end else begin
            first_in = 1'b1;
            if (lead2) begin
               acc_in = {{(u8u16_pkg::CODE_W-5){1'b0}}, in_byte_ff[4:0]};
               rem_in = u8u16_pkg::SEQ_TWO;
            end else if (lead3) begin
               acc_in = {{(u8u16_pkg::CODE_W-4){1'b0}}, in_byte_ff[3:0]};
               rem_in = u8u16_pkg::SEQ_THREE;
            end else begin
               acc_in = {{(u8u16_pkg::CODE_W-3){1'b0}}, in_byte_ff[2:0]};
               rem_in = u8u16_pkg::SEQ_FOUR;
            end
            seq_in = rem_in;
         end
      end else if (!cont_ok || first_bad) begin
         fail = 1'b1;
      end else if (rem_dec != 2'd0) begin
         if (in_eos_ff) begin
            fail = 1'b1;
         end else begin
            acc_in   = acc_sh;
            rem_in   = rem_dec;
            first_in = 1'b0;
         end
      end else begin
         // Sequence complete: drop to idle and emit one word or a pair
         acc_in   = '0;
         rem_in   = 2'd0;
         seq_in   = 2'd0;
         first_in = 1'b0;
         if (acc_sh < u8u16_pkg::SUPP_BASE) begin
            res_n   = 2'd1;
            r0.word = acc_sh[u8u16_pkg::WORD_W-1:0];
            r0.last = 1'b1;
         end else begin
            res_n   = 2'd2;
            r0.word = u8u16_pkg::HIGH_SURR | {6'd0, cp_off[19:10]};
            r1.word = u8u16_pkg::LOW_SURR | {6'd0, cp_off[9:0]};
            r1.last = 1'b1;
         end
      end
      if (fail) begin
         acc_in   = '0;
         rem_in   = 2'd0;
         seq_in   = 2'd0;
         first_in = 1'b0;
         res_n    = 2'd1;
         r0.word  = '0;
         r0.err   = 1'b1;
         r0.last  = 1'b1;
      end
   end

   // Result buffer: pop head, then append the new beats
   always_comb begin
      pop   = rsp_tvalid && rsp_tready;
      base0 = pop ? e1_ff : e0_ff;
      cnt_p = pop ? (cnt_ff - 2'd1) : cnt_ff;
      advance = in_valid_ff && (res_n <= (2'd2 - cnt_p));
      e0_in  = base0;
      e1_in  = e1_ff;
      cnt_in = cnt_p;
      if (advance) begin
         cnt_in = cnt_p + res_n;
         if (cnt_p == 2'd0) begin
            e0_in = r0;
            e1_in = r1;
         end else if (cnt_p == 2'd1) begin
            e1_in = r0;
         end
      end
      in_valid_in = (in_valid_ff && !advance) || (req_tvalid && req_tready);
   end

   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = e0_ff.word;
   assign rsp_tuser  = e0_ff.err;
   assign rsp_tlast  = e0_ff.last;

   // Hold control state; payload loads without reset
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
         acc_ff      <= '0;
         rem_ff      <= 2'd0;
         seq_ff      <= 2'd0;
         first_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         if (advance) begin
            acc_ff   <= acc_in;
            rem_ff   <= rem_in;
            seq_ff   <= seq_in;
            first_ff <= first_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eos_ff  <= req_tlast;
      end
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

   // A beat that is not last of its run always has its partner buffered
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0 && !e0_ff.last) |-> (cnt_ff == 2'd2))
      else $error("high surrogate buffered without low surrogate");

   // Consuming an end-of-stream byte leaves the decoder idle
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_eos_ff) |=> (rem_ff == 2'd0))
      else $error("decoder not idle after end of stream");

   // An error beat always drops the decoder to idle
   assert property (@(posedge clock) disable iff (reset)
      (advance && fail) |=> (rem_ff == 2'd0 && !first_ff))
      else $error("decoder not idle after error");

   // The buffer never overfills
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result buffer overflow");

endmodule
